>>> rtl/core/qcst_pkg.sv
// Package for the quadruple cover square test: default coordinate width,
// stream word widths and the bit positions of the result word fields.
// No dependencies.
package qcst_pkg;

    localparam int COORD_BITS_DEF = 12;

    // result word field positions, lowest bit up
    localparam int MASK_LSB = 0;
    localparam int FULL_BIT = 3;
    localparam int RECT_BIT = 4;
    localparam int PRIM_LSB = 5;

    // input word: coord_a (w), coord_b, coord_c, coord_d (w+1 each), byte padded
    function automatic int in_width(input int w);
        return ((4 * w + 3 + 7) / 8) * 8;
    endfunction

    // result word: mask (3), full_cover, is_rectangle, four prim entries (w+1 each)
    function automatic int out_width(input int w);
        return ((5 + 4 * (w + 1) + 7) / 8) * 8;
    endfunction

endpackage

>>> rtl/core/quadruple_cover_square_test_top.sv
// Quadruple cover square test: pipelined perfect-square test of three quartic
// radicands, rectangle flag and primitive normalized tuple.
// Depends on qcst_pkg.
//
//  channel | dir | handshake                 | word contents (lowest bit up)
//  --------+-----+---------------------------+---------------------------------------
//  s_      | in  | s_tvalid / s_tready       | coord_a, coord_b, coord_c, coord_d
//  m_      | out | m_tvalid / m_tready       | square_mask, full_cover, is_rectangle,
//          |     |                           | prim_a, prim_b, prim_c, prim_d
//
// One word enters per cycle while no result waits unaccepted on m_. The binary gcd
// chain sets the pipe's length: two phases of 4*COORD_BITS+4 steps each, one step
// per stage, followed by COORD_BITS+1 stages of restoring division, one quotient bit
// per stage. The whole pipe advances together: while a result sits unaccepted on m_,
// every stage holds and s_tready drops. Reset clears only the valid bits.
module quadruple_cover_square_test_top #(
    parameter int COORD_BITS = qcst_pkg::COORD_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // coord_a, coord_b, coord_c, coord_d, zero pad
    input  logic [qcst_pkg::in_width(COORD_BITS)-1:0]     s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // square_mask, full_cover, is_rectangle, prim_a, prim_b, prim_c, prim_d, zero pad
    output logic [qcst_pkg::out_width(COORD_BITS)-1:0]    m_tdata
);
    import qcst_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int VW    = W + 1;          // signed coordinate / magnitude width
    localparam int FW    = W + 2;          // factor width (sum of two coordinates)
    localparam int PW    = 2 * FW;         // product of two factors
    localparam int RW    = 4 * W + 5;      // signed radicand width
    localparam int SQ    = 2 * W + 2;      // root bits
    localparam int RADW  = 2 * SQ;         // radicand magnitude bits
    localparam int REMW  = SQ + 2;         // sqrt remainder bits
    localparam int MW    = 2 * VW;         // magnitude pair product
    localparam int GS    = 4 * W + 4;      // binary gcd steps per phase
    localparam int GN    = 2 * GS;         // gcd stages in total
    localparam int KW    = $clog2(VW + 1); // common power-of-two count
    localparam int DS    = VW;             // division stages
    localparam int MDN   = GN - SQ;        // mask delay to meet the gcd chain
    localparam int NSTG  = 3 + GN + DS + 1;
    localparam int OUT_W = out_width(COORD_BITS);

    typedef struct packed {
        logic [VW-1:0] u;
        logic [VW-1:0] v;
        logic [KW-1:0] k;
    } gcd_t;

    typedef struct packed {
        logic [3:0][VW-1:0] v;
        logic [2:0][PW-1:0] lo;
        logic [2:0][PW-1:0] hi;
        logic [5:0][MW-1:0] mp;
    } s1_t;

    typedef struct packed {
        logic [3:0][VW-1:0] v;
        logic [2:0][RW-1:0] rad;
        logic               rect;
    } s2_t;

    typedef struct packed {
        logic [2:0][RADW-1:0] rad;
        logic [2:0][REMW-1:0] rem;
        logic [2:0][SQ-1:0]   root;
        logic [2:0]           neg;
    } sqs_t;

    typedef struct packed {
        gcd_t [1:0]         gp;
        logic [3:0][VW-1:0] v;
        logic               rect;
    } gst_t;

    typedef struct packed {
        logic [3:0][VW-1:0] r;
        logic [3:0][VW-1:0] nq;
        logic [VW-1:0]      g;
        logic [3:0]         sgn;
        logic [3:0]         nz;
        logic [2:0]         mask;
        logic               rect;
    } dv_t;

    typedef struct packed {
        logic [3:0][VW-1:0] prim;
        logic               rect;
        logic               full;
        logic [2:0]         mask;
    } out_t;

    function automatic logic [VW-1:0] mag(input logic [VW-1:0] x);
        return x[VW-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic signed [FW-1:0] fext(input logic [VW-1:0] x);
        return FW'($signed(x));
    endfunction

    function automatic logic signed [FW-1:0] fsum(input logic [VW-1:0] x,
                                                  input logic [VW-1:0] y);
        return FW'($signed(x)) + FW'($signed(y));
    endfunction

    // one binary gcd step; hold once either operand reaches zero
    function automatic gcd_t gcd_step(input gcd_t x);
        gcd_t y;
        y = x;
        if (x.u == '0 || x.v == '0) begin
            y = x;
        end
        else if (!x.u[0] && !x.v[0]) begin
            y.u = x.u >> 1;
            y.v = x.v >> 1;
            y.k = x.k + 1'b1;
        end
        else if (!x.u[0]) begin
            y.u = x.u >> 1;
        end
        else if (!x.v[0]) begin
            y.v = x.v >> 1;
        end
        else if (x.u >= x.v) begin
            y.u = x.u - x.v;
        end
        else begin
            y.v = x.v - x.u;
        end
        return y;
    endfunction

    function automatic logic [VW-1:0] gcd_val(input gcd_t x);
        return (x.u | x.v) << x.k;
    endfunction

    logic              en;
    logic [NSTG-1:0]   vld_reg;
    logic [3:0][VW-1:0] st0_v_reg;
    s1_t               s1_next, s1_reg;
    s2_t               s2_next, s2_reg;
    sqs_t              sq_init;
    sqs_t              sq_reg [SQ];
    logic [2:0]        sq_mask;
    logic [2:0]        md_reg [MDN];
    gst_t              gst_init;
    gst_t              gst_reg [GN];
    dv_t               dv_init;
    dv_t               dv_reg [DS];
    out_t              out_next, out_reg;

    // the whole pipe moves unless a finished word waits on m_
    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = OUT_W'({out_reg.prim[3], out_reg.prim[2], out_reg.prim[1],
                              out_reg.prim[0], out_reg.rect, out_reg.full,
                              out_reg.mask});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid && s_tready};
        end
    end

    // front: unpack, factor products, radicands and rectangle test
    always_comb
    begin
        s1_next.v     = st0_v_reg;
        s1_next.lo[0] = fext(st0_v_reg[0]) * fsum(st0_v_reg[0], st0_v_reg[1]);
        s1_next.hi[0] = fsum(st0_v_reg[0], st0_v_reg[2]) * fsum(st0_v_reg[0], st0_v_reg[3]);
        s1_next.lo[1] = fext(st0_v_reg[1]) * fsum(st0_v_reg[1], st0_v_reg[0]);
        s1_next.hi[1] = fsum(st0_v_reg[1], st0_v_reg[2]) * fsum(st0_v_reg[1], st0_v_reg[3]);
        s1_next.lo[2] = fext(st0_v_reg[2]) * fsum(st0_v_reg[2], st0_v_reg[0]);
        s1_next.hi[2] = fsum(st0_v_reg[2], st0_v_reg[1]) * fsum(st0_v_reg[2], st0_v_reg[3]);
        s1_next.mp[0] = mag(st0_v_reg[0]) * mag(st0_v_reg[1]);
        s1_next.mp[1] = mag(st0_v_reg[2]) * mag(st0_v_reg[3]);
        s1_next.mp[2] = mag(st0_v_reg[0]) * mag(st0_v_reg[2]);
        s1_next.mp[3] = mag(st0_v_reg[1]) * mag(st0_v_reg[3]);
        s1_next.mp[4] = mag(st0_v_reg[0]) * mag(st0_v_reg[3]);
        s1_next.mp[5] = mag(st0_v_reg[1]) * mag(st0_v_reg[2]);
    end

    always_comb
    begin
        logic signed [2*PW-1:0] prod;
        s2_next.v    = s1_reg.v;
        s2_next.rect = (s1_reg.mp[0] == s1_reg.mp[1]) || (s1_reg.mp[2] == s1_reg.mp[3]) ||
                       (s1_reg.mp[4] == s1_reg.mp[5]);
        for (int j = 0; j < 3; j++)
        begin
            prod           = $signed(s1_reg.lo[j]) * $signed(s1_reg.hi[j]);
            s2_next.rad[j] = prod[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st0_v_reg <= {s_tdata[W+2*VW +: VW], s_tdata[W+VW +: VW], s_tdata[W +: VW],
                          {1'b0, s_tdata[W-1:0]}};
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
        end
    end

    // square root chain: one root bit per stage, three radicands side by side
    always_comb
    begin
        sq_init = '0;
        for (int j = 0; j < 3; j++)
        begin
            sq_init.rad[j] = s2_reg.rad[j][RADW-1:0];
            sq_init.neg[j] = s2_reg.rad[j][RW-1];
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sq
        sqs_t sin, snx;
        if (k == 0)
        begin : g_first
            assign sin = sq_init;
        end
        else
        begin : g_rest
            assign sin = sq_reg[k-1];
        end

        always_comb
        begin
            logic [SQ+3:0] cur;
            logic [SQ+3:0] trial;
            snx = sin;
            for (int j = 0; j < 3; j++)
            begin
                cur   = {sin.rem[j], sin.rad[j][RADW-1 -: 2]};
                trial = (SQ + 4)'({sin.root[j], 2'b01});
                if (cur >= trial)
                begin
                    snx.rem[j]  = REMW'(cur - trial);
                    snx.root[j] = {sin.root[j][SQ-2:0], 1'b1};
                end
                else
                begin
                    snx.rem[j]  = cur[REMW-1:0];
                    snx.root[j] = {sin.root[j][SQ-2:0], 1'b0};
                end
                snx.rad[j] = {sin.rad[j][RADW-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k] <= snx;
            end
        end
    end

    // a negative radicand is never a square; zero remainder means exact root
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq_mask[j] = !sq_reg[SQ-1].neg[j] && (sq_reg[SQ-1].rem[j] == '0);
        end
    end

    // hold the mask until the gcd chain catches up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg[0] <= sq_mask;
            for (int i = 1; i < MDN; i++)
            begin
                md_reg[i] <= md_reg[i-1];
            end
        end
    end

    // gcd chain: phase one runs gcd(|a|,|b|) and gcd(|c|,|d|), phase two joins them
    always_comb
    begin
        gst_init         = '0;
        gst_init.v       = s2_reg.v;
        gst_init.rect    = s2_reg.rect;
        gst_init.gp[0].u = mag(s2_reg.v[0]);
        gst_init.gp[0].v = mag(s2_reg.v[1]);
        gst_init.gp[1].u = mag(s2_reg.v[2]);
        gst_init.gp[1].v = mag(s2_reg.v[3]);
    end

    for (genvar k = 0; k < GN; k++)
    begin : g_gcd
        gst_t gin, gnx;
        if (k == 0)
        begin : g_first
            assign gin = gst_init;
        end
        else if (k == GS)
        begin : g_join
            always_comb
            begin
                gin          = gst_reg[k-1];
                gin.gp[0].u  = gcd_val(gst_reg[k-1].gp[0]);
                gin.gp[0].v  = gcd_val(gst_reg[k-1].gp[1]);
                gin.gp[0].k  = '0;
                gin.gp[1]    = '0;
            end
        end
        else
        begin : g_rest
            assign gin = gst_reg[k-1];
        end

        always_comb
        begin
            gnx       = gin;
            gnx.gp[0] = gcd_step(gin.gp[0]);
            gnx.gp[1] = gcd_step(gin.gp[1]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                gst_reg[k] <= gnx;
            end
        end
    end

    // division chain: |v| / g, one quotient bit per stage, four lanes
    always_comb
    begin
        dv_init      = '0;
        dv_init.g    = gcd_val(gst_reg[GN-1].gp[0]);
        dv_init.mask = md_reg[MDN-1];
        dv_init.rect = gst_reg[GN-1].rect;
        for (int i = 0; i < 4; i++)
        begin
            dv_init.nq[i]  = mag(gst_reg[GN-1].v[i]);
            dv_init.sgn[i] = gst_reg[GN-1].v[i][VW-1];
            dv_init.nz[i]  = (gst_reg[GN-1].v[i] != '0);
        end
    end

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        dv_t din, dnx;
        if (k == 0)
        begin : g_first
            assign din = dv_init;
        end
        else
        begin : g_rest
            assign din = dv_reg[k-1];
        end

        always_comb
        begin
            logic [VW:0] cur;
            logic        qb;
            dnx = din;
            for (int i = 0; i < 4; i++)
            begin
                cur = {din.r[i], din.nq[i][VW-1]};
                if (cur >= {1'b0, din.g})
                begin
                    dnx.r[i] = VW'(cur - {1'b0, din.g});
                    qb       = 1'b1;
                end
                else
                begin
                    dnx.r[i] = cur[VW-1:0];
                    qb       = 1'b0;
                end
                dnx.nq[i] = {din.nq[i][VW-2:0], qb};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k] <= dnx;
            end
        end
    end

    // restore signs, then negate the tuple when its first nonzero entry is negative
    always_comb
    begin
        logic          flip;
        logic [VW-1:0] q;
        flip = dv_reg[DS-1].nz[0] ? dv_reg[DS-1].sgn[0] :
               dv_reg[DS-1].nz[1] ? dv_reg[DS-1].sgn[1] :
               dv_reg[DS-1].nz[2] ? dv_reg[DS-1].sgn[2] :
               (dv_reg[DS-1].nz[3] && dv_reg[DS-1].sgn[3]);
        out_next.mask = dv_reg[DS-1].mask;
        out_next.full = (dv_reg[DS-1].mask == 3'b111);
        out_next.rect = dv_reg[DS-1].rect;
        for (int i = 0; i < 4; i++)
        begin
            q = (dv_reg[DS-1].g == '0) ? '0 : dv_reg[DS-1].nq[i];
            out_next.prim[i] = (dv_reg[DS-1].sgn[i] ^ flip) ? (~q + 1'b1) : q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> rtl/core/qcst_check.sv
// Port-level checker for the quadruple cover square test, bound to the top level.
// Depends on qcst_pkg and quadruple_cover_square_test_top.
module qcst_check #(
    parameter int COORD_BITS = qcst_pkg::COORD_BITS_DEF
) (
    input logic                                       clk,
    input logic                                       rst_n,
    input logic                                       s_tready,
    input logic                                       m_tvalid,
    input logic                                       m_tready,
    input logic [qcst_pkg::out_width(COORD_BITS)-1:0] m_tdata
);
    import qcst_pkg::*;

    localparam int PA_MSB = PRIM_LSB + COORD_BITS;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // input side advances exactly when the output side can drain
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[FULL_BIT] == (m_tdata[MASK_LSB +: 3] == 3'b111)))
        else $error("full_cover disagrees with square_mask");

    // prim_a comes from a nonnegative entry and is flipped only when it is zero
    a_prim_a: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[PA_MSB])
        else $error("prim_a negative");

    a_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind quadruple_cover_square_test_top qcst_check #(.COORD_BITS(COORD_BITS)) u_qcst_check (.*);

>>> test/testbench.sv
// Testbench for the quadruple cover square test: drives coordinate words on s_,
// checks every result word on m_ against a built-in predictor.
// Depends on qcst_pkg and quadruple_cover_square_test_top.
module testbench;
    import qcst_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int IW = in_width(CW);
    localparam int OW = out_width(CW);
    localparam int LATENCY = 9 * CW + 13;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]      square_mask;
        logic            full_cover;
        logic            is_rectangle;
        logic [CW:0]     prim_a;
        logic [CW:0]     prim_b;
        logic [CW:0]     prim_c;
        logic [CW:0]     prim_d;
    } cover_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // coord_a, coord_b, coord_c, coord_d, zero pad
    logic [IW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // square_mask, full_cover, is_rectangle, prim_a, prim_b, prim_c, prim_d, zero pad
    logic [OW-1:0] m_tdata;

    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    quadruple_cover_square_test_top #(.COORD_BITS(CW)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 checked_count, what, got, want);
    endtask

    function automatic bit perfect_square(input longint x);
        longint r;
        if (x < 0)
            return 0;
        r = longint'($sqrt(real'(x)));
        // fix up any rounding of the float root
        while (r * r > x)
            r--;
        while ((r + 1) * (r + 1) <= x)
            r++;
        return r * r == x;
    endfunction

    function automatic longint abs_val(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint gcd_of(input longint x, input longint y);
        longint t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Work out the expected result word for one coordinate word.
    function automatic cover_result_t predict_cover(input logic [IW-1:0] word);
        longint v[4];
        longint m[4];
        longint g;
        cover_result_t r;
        bit neg;
        logic [CW:0] p[4];
        v[0] = longint'(word[CW-1:0]);
        v[1] = longint'($signed(word[2*CW:CW]));
        v[2] = longint'($signed(word[3*CW+1:2*CW+1]));
        v[3] = longint'($signed(word[4*CW+2:3*CW+2]));
        r.square_mask[0] = perfect_square(v[0] * (v[0] + v[1]) * (v[0] + v[2]) * (v[0] + v[3]));
        r.square_mask[1] = perfect_square(v[1] * (v[1] + v[0]) * (v[1] + v[2]) * (v[1] + v[3]));
        r.square_mask[2] = perfect_square(v[2] * (v[2] + v[0]) * (v[2] + v[1]) * (v[2] + v[3]));
        r.full_cover = &r.square_mask;
        for (int i = 0; i < 4; i++)
            m[i] = abs_val(v[i]);
        r.is_rectangle = (m[0] * m[1] == m[2] * m[3]) || (m[0] * m[2] == m[1] * m[3])
                      || (m[0] * m[3] == m[1] * m[2]);
        g = gcd_of(gcd_of(m[0], m[1]), gcd_of(m[2], m[3]));
        neg = 0;
        for (int i = 0; i < 4; i++)
            v[i] = (g != 0) ? v[i] / g : 0;
        for (int i = 3; i >= 0; i--)
            if (v[i] != 0)
                neg = v[i] < 0;
        for (int i = 0; i < 4; i++)
            p[i] = neg ? (CW+1)'(0) - v[i][CW:0] : v[i][CW:0];
        r.prim_a = p[0];
        r.prim_b = p[1];
        r.prim_c = p[2];
        r.prim_d = p[3];
        return r;
    endfunction

    class cover_scoreboard;
        cover_result_t pending_results[$];

        function void note_input(input logic [IW-1:0] word);
            pending_results = {pending_results, predict_cover(word)};
        endfunction

        task check_result(input logic [OW-1:0] word);
            cover_result_t got;
            cover_result_t want;
            got.square_mask  = word[MASK_LSB +: 3];
            got.full_cover   = word[FULL_BIT];
            got.is_rectangle = word[RECT_BIT];
            got.prim_a = word[PRIM_LSB +: CW+1];
            got.prim_b = word[PRIM_LSB + (CW+1) +: CW+1];
            got.prim_c = word[PRIM_LSB + 2*(CW+1) +: CW+1];
            got.prim_d = word[PRIM_LSB + 3*(CW+1) +: CW+1];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.square_mask != want.square_mask)
                report_mismatch("square_mask", got.square_mask, want.square_mask);
            if (got.full_cover != want.full_cover)
                report_mismatch("full_cover", got.full_cover, want.full_cover);
            if (got.is_rectangle != want.is_rectangle)
                report_mismatch("is_rectangle", got.is_rectangle, want.is_rectangle);
            if (got.prim_a != want.prim_a)
                report_mismatch("prim_a", $signed(got.prim_a), $signed(want.prim_a));
            if (got.prim_b != want.prim_b)
                report_mismatch("prim_b", $signed(got.prim_b), $signed(want.prim_b));
            if (got.prim_c != want.prim_c)
                report_mismatch("prim_c", $signed(got.prim_c), $signed(want.prim_c));
            if (got.prim_d != want.prim_d)
                report_mismatch("prim_d", $signed(got.prim_d), $signed(want.prim_d));
        endtask
    endclass

    cover_scoreboard board = new();

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: check every accepted result word, stall at random.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata);
            checked_count++;
        end
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic [IW-1:0] pack_coords(input longint a, input longint b,
                                                  input longint c, input longint d);
        logic [IW-1:0] w;
        w = '0;
        w[CW-1:0] = a[CW-1:0];
        w[2*CW:CW] = b[CW:0];
        w[3*CW+1:2*CW+1] = c[CW:0];
        w[4*CW+2:3*CW+2] = d[CW:0];
        return w;
    endfunction

    // Present one word, hold it until accepted; idle beforehand at random.
    task automatic send_word(input logic [IW-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(word);
        sent_count++;
    endtask

    function automatic longint rand_signed();
        case ($urandom_range(5))
            0: return longint'($urandom_range(8)) - 4;
            1: return longint'($urandom_range(8190)) - 4095;
            2: return $urandom_range(1) ? 4095 : -4095;
            default: return longint'($urandom_range(60)) - 30;
        endcase
    endfunction

    // Build a word likely to hit squares and rectangles: small entries,
    // scaled copies and proportional pairs mixed with full-range noise.
    function automatic logic [IW-1:0] random_word();
        longint a, b, c, d, k;
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
        begin
            k = $urandom_range(1, 100);
            a = $urandom_range(1, 40);
            b = longint'($urandom_range(80)) - 40;
            c = longint'($urandom_range(80)) - 40;
            d = (sel == 0 && a != 0) ? (b * c) / a : longint'($urandom_range(80)) - 40;
            if (abs_val(d * k) > 4095 || abs_val(b * k) > 4095
                || abs_val(c * k) > 4095 || a * k > 4095)
                k = 1;
            if (abs_val(d) > 4095)
                d = 0;
            return pack_coords(a * k, b * k, c * k, d * k);
        end
        if (sel == 4)
        begin
            // raw bits, including a zero and the most negative field values
            a = $urandom_range(4095, 0);
            b = longint'($urandom_range(8191)) - 4096;
            c = longint'($urandom_range(8191)) - 4096;
            d = longint'($urandom_range(8191)) - 4096;
            return pack_coords(a, b, c, d);
        end
        a = $urandom_range(1, 4095);
        if ($urandom_range(1))
            a = $urandom_range(1, 30);
        return pack_coords(a, rand_signed(), rand_signed(), rand_signed());
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: field extremes, zero entries, all-zero tuple,
        // negated most negative value, known squares and rectangles.
        send_word(pack_coords(1, 0, 0, 0));
        send_word(pack_coords(0, 0, 0, 0));
        send_word(pack_coords(4095, 4095, 4095, 4095));
        send_word(pack_coords(4095, -4095, -4095, -4095));
        send_word(pack_coords(1, -4095, 4095, -4095));
        send_word(pack_coords(0, -4096, 0, 0));
        send_word(pack_coords(0, 0, -4096, 2));
        send_word(pack_coords(0, 0, 0, -4096));
        send_word(pack_coords(0, -4096, -4096, -4096));
        send_word(pack_coords(0, -3, 6, 9));
        send_word(pack_coords(2, 3, 4, 6));
        send_word(pack_coords(6, -4, -3, 2));
        send_word(pack_coords(1, 1, 1, 1));
        send_word(pack_coords(1, -1, 2, 3));
        send_word(pack_coords(3, 1, -2, -3));
        send_word(pack_coords(2048, 1024, -512, 256));
        send_word(pack_coords(1, 2, 3, 5));
        send_word(pack_coords(4095, -1, 1, 0));
        send_word(pack_coords(2730, -1365, 1365, -2730));
        send_word(pack_coords(1, 3, 8, 120));

        run_phase(0, 0, 500);
        run_phase(49, 0, 480);
        run_phase(0, 49, 480);
        run_phase(38, 38, 480);
        s_tvalid <= 1'b0;

        // Drain, then idle past the pipeline latency.
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("sent %0d coordinate words, checked %0d result words,", sent_count,
                 checked_count);
        $display("over phases with no idling, sender gaps, receiver stalls and both");
        if (error_count == 0 && board.pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
